// ===== rtl/kedsw_pkg.sv =====
// Package for the key event detector with stuck-key watchdog.
// Holds the transaction types, key map constants and back-end state codes.
// No dependencies.
package kedsw_pkg;

    localparam int ROW_KEYS        = 14;
    localparam int MAP_BITS        = 56;
    localparam int KEY_ID_W        = 6;
    localparam int TIME_W          = 32;
    localparam int KEY_COUNT_DEF   = 56;
    localparam int MAX_EVENTS_DEF  = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam logic [TIME_W-1:0] STUCK_RESET = 32'd8000;

    localparam int KEY_FN    = 2 * ROW_KEYS + 0;
    localparam int KEY_SHIFT = 2 * ROW_KEYS + 1;
    localparam int KEY_CTRL  = 3 * ROW_KEYS + 0;
    localparam int KEY_ALT   = 3 * ROW_KEYS + 2;

    typedef struct packed {
        logic [MAP_BITS-1:0] key_map;
        logic [TIME_W-1:0]   now_ms;
    } scan_in_t;

    typedef struct packed {
        logic [MAP_BITS-1:0] key_map;
        logic [TIME_W-1:0]   now_ms;
        logic                fn_down;
        logic                shift_down;
        logic                ctrl_down;
        logic                alt_down;
    } scan_t;

    typedef struct packed {
        logic [KEY_ID_W-1:0] key_id;
        logic                pressed;
        logic                fn_down;
        logic                shift_down;
        logic                ctrl_down;
        logic                alt_down;
        logic                forced_release;
        logic                last_event;
    } evt_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_WALK,
        BACK_FLUSH
    } back_state_t;

endpackage

// ===== rtl/kedsw_front.sv =====
// Front end: accepts scan transactions and decodes the modifier keys.
// Depends on kedsw_pkg; feeds kedsw_fifo.
module kedsw_front
(
    input  logic              scan_valid,
    output logic              scan_ready,
    input  kedsw_pkg::scan_in_t scan,
    input  logic              q_full,
    output logic              push,
    output kedsw_pkg::scan_t  push_data
);

    assign scan_ready = !q_full;
    assign push       = scan_valid && !q_full;

    always_comb
    begin
        push_data.key_map    = scan.key_map;
        push_data.now_ms     = scan.now_ms;
        push_data.fn_down    = scan.key_map[kedsw_pkg::KEY_FN];
        push_data.shift_down = scan.key_map[kedsw_pkg::KEY_SHIFT];
        push_data.ctrl_down  = scan.key_map[kedsw_pkg::KEY_CTRL];
        push_data.alt_down   = scan.key_map[kedsw_pkg::KEY_ALT];
    end

endmodule

// ===== rtl/kedsw_fifo.sv =====
// Short queue of decoded scans between front and back end.
// Depends on kedsw_pkg for the entry type.
module kedsw_fifo
#(
    parameter int DEPTH = kedsw_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  kedsw_pkg::scan_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output kedsw_pkg::scan_t data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kedsw_pkg::scan_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign valid  = (count_reg != '0);
    assign data   = entry_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/kedsw_back.sv =====
// Back end: walks the keys of one scan, keeps held flags and press times,
// and emits press, release and forced-release events. Depends on kedsw_pkg.
module kedsw_back
#(
    parameter int KEY_COUNT  = kedsw_pkg::KEY_COUNT_DEF,
    parameter int MAX_EVENTS = kedsw_pkg::MAX_EVENTS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  kedsw_pkg::scan_t               q_data,
    output logic                           q_pop,
    input  logic [kedsw_pkg::TIME_W-1:0]   stuck_time,
    output logic                           evt_valid,
    input  logic                           evt_ready,
    output kedsw_pkg::evt_t                evt
);

    localparam int IDX_W = $clog2(KEY_COUNT);
    localparam int MAP_W = 1 << IDX_W;
    localparam int CNT_W = $clog2(MAX_EVENTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_COUNT - 1);

    kedsw_pkg::back_state_t state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [KEY_COUNT-1:0] held_reg, held_next;
    logic                 pend_valid_reg, pend_valid_next;
    kedsw_pkg::evt_t      pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    kedsw_pkg::evt_t      out_reg, out_next;

    logic [kedsw_pkg::TIME_W-1:0] press_mem [KEY_COUNT];
    logic [kedsw_pkg::TIME_W-1:0] pt_rdata_reg;
    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    logic                         wr_en;

    logic [MAP_W-1:0]             map_ext;
    logic [kedsw_pkg::TIME_W-1:0] elapsed;
    logic down, held, press, release_ev, forced, emit, emit_ok, out_free;
    kedsw_pkg::evt_t              new_ev;

    assign map_ext    = MAP_W'(q_data.key_map);
    assign down       = map_ext[idx_reg];
    assign held       = held_reg[idx_reg];
    assign elapsed    = q_data.now_ms - pt_rdata_reg;
    assign press      = down && !held;
    assign release_ev = !down && held;
    assign forced     = down && held && (elapsed > stuck_time);
    assign emit       = press || release_ev || forced;
    assign emit_ok    = emit && (cnt_reg < CNT_W'(MAX_EVENTS));
    assign out_free   = !out_valid_reg || evt_ready;

    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

    always_comb
    begin
        new_ev.key_id         = kedsw_pkg::KEY_ID_W'(idx_reg);
        new_ev.pressed        = press;
        new_ev.fn_down        = q_data.fn_down;
        new_ev.shift_down     = q_data.shift_down;
        new_ev.ctrl_down      = q_data.ctrl_down;
        new_ev.alt_down       = q_data.alt_down;
        new_ev.forced_release = forced;
        new_ev.last_event     = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        held_next       = held_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg + 1'b1;
        wr_en           = 1'b0;

        if (out_valid_reg && evt_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            kedsw_pkg::BACK_IDLE:
            begin
                if (q_valid)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    cnt_next   = '0;
                    state_next = kedsw_pkg::BACK_WALK;
                end
            end
            kedsw_pkg::BACK_WALK:
            begin
                if (!(emit_ok && pend_valid_reg && !out_free))
                begin
                    if (emit)
                    begin
                        held_next[idx_reg] = press;
                    end
                    wr_en = press;
                    if (emit_ok)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = new_ev;
                        pend_valid_next = 1'b1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = kedsw_pkg::BACK_FLUSH;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            kedsw_pkg::BACK_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    q_pop      = 1'b1;
                    state_next = kedsw_pkg::BACK_IDLE;
                end
                else if (out_free)
                begin
                    out_next            = pend_reg;
                    out_next.last_event = 1'b1;
                    out_valid_next      = 1'b1;
                    pend_valid_next     = 1'b0;
                    q_pop               = 1'b1;
                    state_next          = kedsw_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = kedsw_pkg::BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kedsw_pkg::BACK_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            held_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            held_reg       <= held_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            press_mem[idx_reg] <= q_data.now_ms;
        end
        if (rd_en)
        begin
            pt_rdata_reg <= press_mem[rd_addr];
        end
    end

endmodule

// ===== rtl/key_event_detector_stuck_watchdog.sv =====
// Key event detector with stuck-key watchdog: top level.
// Depends on kedsw_pkg, kedsw_front, kedsw_fifo and kedsw_back.
//
// Each scan transaction (key map plus millisecond time) is decoded and queued,
// then the back end walks the keys one per cycle in id order, pausing while the
// event port holds back a full output with a further event due, and returns the
// press, release and forced-release events of that scan, at most MAX_EVENTS,
// with last_event set on the final one and nothing for a scan without change.
// The one-key-per-cycle walk runs over the single read port of the press-time
// memory; the scan being walked stays at the head of a two-entry queue, so one
// more scan is accepted meanwhile. Held flags clear at reset, so no clearing
// pass runs.
// stuck_time_reg (milliseconds) resets to 8000 and is written through cfg_we/cfg_data.
module key_event_detector_stuck_watchdog
#(
    parameter int KEY_COUNT  = kedsw_pkg::KEY_COUNT_DEF,
    parameter int MAX_EVENTS = kedsw_pkg::MAX_EVENTS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         scan_valid,
    output logic                         scan_ready,
    input  kedsw_pkg::scan_in_t          scan,
    output logic                         evt_valid,
    input  logic                         evt_ready,
    output kedsw_pkg::evt_t              evt,
    input  logic                         cfg_we,
    input  logic [kedsw_pkg::TIME_W-1:0] cfg_data
);

    logic [kedsw_pkg::TIME_W-1:0] stuck_time_reg;
    logic             q_full, q_push, q_pop, q_valid;
    kedsw_pkg::scan_t q_push_data, q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stuck_time_reg <= kedsw_pkg::STUCK_RESET;
        end
        else if (cfg_we)
        begin
            stuck_time_reg <= cfg_data;
        end
    end

    kedsw_front u_front
    (
        .scan_valid (scan_valid),
        .scan_ready (scan_ready),
        .scan       (scan),
        .q_full     (q_full),
        .push       (q_push),
        .push_data  (q_push_data)
    );

    kedsw_fifo #(.DEPTH(kedsw_pkg::QUEUE_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_data)
    );

    kedsw_back #(.KEY_COUNT(KEY_COUNT), .MAX_EVENTS(MAX_EVENTS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .stuck_time (stuck_time_reg),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt        (evt)
    );

endmodule

// ===== rtl/kedsw_chk.sv =====
// Port-level checker for the key event detector, bound to the top level.
// Depends on kedsw_pkg.
module kedsw_chk
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         evt_valid,
    input logic                         evt_ready,
    input kedsw_pkg::evt_t              evt
);

    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt))
        else $error("event transaction changed while stalled");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> evt.key_id < kedsw_pkg::KEY_ID_W'(kedsw_pkg::MAP_BITS))
        else $error("event for a key outside the map");

    a_press_not_forced: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt.pressed |-> !evt.forced_release)
        else $error("press event flagged as forced release");

    a_fn_press: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt.pressed
            && evt.key_id == kedsw_pkg::KEY_ID_W'(kedsw_pkg::KEY_FN) |-> evt.fn_down)
        else $error("fn press without fn modifier");

    a_shift_release: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt.pressed && !evt.forced_release
            && evt.key_id == kedsw_pkg::KEY_ID_W'(kedsw_pkg::KEY_SHIFT) |-> !evt.shift_down)
        else $error("shift release with shift modifier still down");

endmodule

bind key_event_detector_stuck_watchdog kedsw_chk u_kedsw_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .evt_valid  (evt_valid),
    .evt_ready  (evt_ready),
    .evt        (evt)
);
